@@ design/assert_macros.svh @@
// Assertion macros for the design files; move_to_front_keyed_list includes them.
// Uses the clk and rst_n names of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/mtfl_pkg.sv @@
// Package of the move-to-front keyed list: widths, codes and shared types.
// No dependencies; used by every module of the block.
package mtfl_pkg;

  localparam int CAPACITY = 256;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  localparam int KEY_W   = 16;
  localparam int VAL_W   = 32;
  localparam int LVL_W   = 4;
  localparam int OUT_COUNT_W = 9;
  localparam int OUT_POS_W   = 8;

  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [OUT_COUNT_W-1:0] out_count_t;
  typedef logic [OUT_POS_W-1:0]   out_pos_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_MOVE   = 1'b1;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_PRESENT   = 3'd1,
    STAT_MOVED     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
    logic [LVL_W-1:0]        level;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             commit;
    count_t           shift_lim;
    logic             load_cmp;
    logic [KEY_W-1:0] cmp_key;
    entry_t           req;
  } cell_ctrl_t;

endpackage

@@ design/mtfl_cell.sv @@
// One list position: holds an entry and a registered key match.
// Depends on mtfl_pkg.
module mtfl_cell (
  input  logic                clk,
  input  mtfl_pkg::pos_t      cell_idx,
  input  mtfl_pkg::cell_ctrl_t ctrl,
  input  mtfl_pkg::count_t    count,
  input  mtfl_pkg::entry_t    prev_entry,
  output mtfl_pkg::entry_t    entry,
  output logic                hit
);

  mtfl_pkg::entry_t entry_r;
  mtfl_pkg::entry_t entry_nxt;
  logic             match_r;
  mtfl_pkg::count_t idx_wide;

  assign idx_wide = mtfl_pkg::count_t'(cell_idx);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.commit) begin
      if (cell_idx == '0) begin
        entry_nxt = ctrl.req;
      end else if (idx_wide <= ctrl.shift_lim) begin
        entry_nxt = prev_entry;
      end
    end
  end

  // The match is taken against the contents after any update in the same
  // cycle, so a new request may be accepted while the previous one commits.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctrl.load_cmp) begin
      match_r <= (entry_nxt.key == ctrl.cmp_key);
    end
  end

  assign entry = entry_r;
  assign hit   = match_r && (idx_wide < count);

endmodule

@@ design/mtfl_search.sv @@
// Reduces the per-cell hit flags to a found flag and a position.
// Depends on mtfl_pkg. Keys in the list are unique, so at most one hit is set.
module mtfl_search (
  input  logic [mtfl_pkg::CAPACITY-1:0] hit_vec,
  output logic                          found,
  output mtfl_pkg::pos_t                pos
);

  always_comb begin
    found = |hit_vec;
    pos   = '0;
    for (int i = 0; i < mtfl_pkg::CAPACITY; i++) begin
      if (hit_vec[i]) begin
        pos = pos | mtfl_pkg::pos_t'(i);
      end
    end
  end

endmodule

@@ design/move_to_front_keyed_list.sv @@
// Move-to-front keyed list: a row of cells, one per list position, that
// search in parallel and shift toward the back together on a commit.
// Depends on mtfl_pkg, mtfl_cell, mtfl_search and assert_macros.svh.
//
// Use: a request (opcode, key, value, level) is taken on the in_ channel
// when in_valid is high and in_stall is low. Each request gives exactly one
// result on the out_ channel (status, entry count, found position), taken
// when out_valid is high and out_stall is low.
// Steps: every cell registers its key compare at the accepting edge, the
// search step reduces the hits to a position, and the update step shifts
// the cells and writes the result into the output register. A new request
// is accepted in the same cycle that the previous one commits, but none is
// accepted during the search step.
// When the receiver stalls with a result still held, the pending request
// waits in its update step and in_stall stays high until the output frees.
// Reset empties the list (count zero), clears out_valid and holds in_stall
// high; cell contents are not cleared, only positions below the count are
// ever searched.
`include "assert_macros.svh"

module move_to_front_keyed_list (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_opcode,
  input  logic [mtfl_pkg::KEY_W-1:0]         in_entry_key,
  input  logic signed [mtfl_pkg::VAL_W-1:0]  in_entry_value,
  input  logic [mtfl_pkg::LVL_W-1:0]         in_entry_level,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         out_status,
  output logic [mtfl_pkg::OUT_COUNT_W-1:0]   out_entry_count,
  output logic [mtfl_pkg::OUT_POS_W-1:0]     out_found_position
);

  mtfl_pkg::state_t     state_r, state_nxt;
  logic                 req_op_r;
  mtfl_pkg::entry_t     req_r;
  logic                 found_r;
  mtfl_pkg::pos_t       pos_r;
  mtfl_pkg::count_t     count_r, count_nxt;
  logic                 out_valid_r;
  mtfl_pkg::status_t    out_status_r;
  mtfl_pkg::out_count_t out_count_r;
  mtfl_pkg::out_pos_t   out_pos_r;

  logic                 accept;
  logic                 out_free;
  logic                 commit;
  logic                 do_write;
  mtfl_pkg::count_t     shift_lim;
  mtfl_pkg::status_t    status_nxt;
  mtfl_pkg::pos_t       pos_report;
  mtfl_pkg::cell_ctrl_t ctrl;

  logic [mtfl_pkg::CAPACITY-1:0] hit_vec;
  mtfl_pkg::entry_t              chain [mtfl_pkg::CAPACITY];
  logic                          srch_found;
  mtfl_pkg::pos_t                srch_pos;

  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == mtfl_pkg::ST_UPDATE) && out_free;
  assign in_stall = !rst_n || !((state_r == mtfl_pkg::ST_IDLE) || commit);
  assign accept   = in_valid && !in_stall;

  // Decision for the request in the update step.
  always_comb begin
    do_write   = 1'b0;
    shift_lim  = '0;
    status_nxt = mtfl_pkg::STAT_NOT_FOUND;
    pos_report = '0;
    count_nxt  = count_r;
    if (req_op_r == mtfl_pkg::OP_INSERT) begin
      if (found_r) begin
        status_nxt = mtfl_pkg::STAT_PRESENT;
        pos_report = pos_r;
      end else if (count_r == mtfl_pkg::count_t'(mtfl_pkg::CAPACITY)) begin
        status_nxt = mtfl_pkg::STAT_FULL;
      end else begin
        do_write   = 1'b1;
        shift_lim  = count_r;
        count_nxt  = count_r + 1'b1;
        status_nxt = mtfl_pkg::STAT_INSERTED;
      end
    end else begin
      if (found_r) begin
        do_write   = 1'b1;
        shift_lim  = mtfl_pkg::count_t'(pos_r);
        status_nxt = mtfl_pkg::STAT_MOVED;
        pos_report = pos_r;
      end
    end
  end

  always_comb begin
    ctrl.commit    = commit && do_write;
    ctrl.shift_lim = shift_lim;
    ctrl.load_cmp  = accept;
    ctrl.cmp_key   = in_entry_key;
    ctrl.req       = req_r;
  end

  for (genvar i = 0; i < mtfl_pkg::CAPACITY; i++) begin : g_cell
    mtfl_pkg::entry_t prev;
    if (i == 0) begin : g_head
      assign prev = req_r;
    end else begin : g_body
      assign prev = chain[i-1];
    end
    mtfl_cell u_cell (
      .clk        (clk),
      .cell_idx   (mtfl_pkg::pos_t'(i)),
      .ctrl       (ctrl),
      .count      (count_r),
      .prev_entry (prev),
      .entry      (chain[i]),
      .hit        (hit_vec[i])
    );
  end

  mtfl_search u_search (
    .hit_vec (hit_vec),
    .found   (srch_found),
    .pos     (srch_pos)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtfl_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = mtfl_pkg::ST_SEARCH;
        end
      end
      mtfl_pkg::ST_SEARCH: begin
        state_nxt = mtfl_pkg::ST_UPDATE;
      end
      mtfl_pkg::ST_UPDATE: begin
        if (accept) begin
          state_nxt = mtfl_pkg::ST_SEARCH;
        end else if (commit) begin
          state_nxt = mtfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mtfl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtfl_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r    <= in_opcode;
      req_r.key   <= in_entry_key;
      req_r.value <= in_entry_value;
      req_r.level <= in_entry_level;
    end
    if (state_r == mtfl_pkg::ST_SEARCH) begin
      found_r <= srch_found;
      pos_r   <= srch_pos;
    end
    if (commit) begin
      out_status_r <= status_nxt;
      out_count_r  <= mtfl_pkg::out_count_t'(count_nxt);
      out_pos_r    <= mtfl_pkg::out_pos_t'(pos_report);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_entry_count    = out_count_r;
  assign out_found_position = out_pos_r;

  `ASSERT_IMPLY(a_unique_hit, state_r == mtfl_pkg::ST_SEARCH, $onehot0(hit_vec))
  `ASSERT_NEXT(a_search_blocks, accept, in_stall && (state_r == mtfl_pkg::ST_SEARCH))
  `ASSERT_IMPLY(a_count_bound, 1'b1, count_r <= mtfl_pkg::count_t'(mtfl_pkg::CAPACITY))
  `ASSERT_NEXT(a_commit_result, commit, out_valid_r)

endmodule

@@ tb/move_to_front_keyed_list_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for move_to_front_keyed_list: directed, random and full-list
// requests are checked against a behavioral copy of the list. Depends on mtfl_pkg and the RTL.
module move_to_front_keyed_list_tb;

  localparam int STUCK_LIMIT  = 4000;
  localparam int SETTLE_TICKS = 10;

  typedef logic [mtfl_pkg::KEY_W-1:0]        key_t;
  typedef logic signed [mtfl_pkg::VAL_W-1:0] value_t;
  typedef logic [mtfl_pkg::LVL_W-1:0]        level_t;

  typedef struct {
    mtfl_pkg::status_t    status;
    mtfl_pkg::out_count_t count;
    mtfl_pkg::out_pos_t   position;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_opcode;
  key_t in_entry_key;
  value_t in_entry_value;
  level_t in_entry_level;
  logic out_valid;
  logic out_stall;
  logic [2:0] out_status;
  mtfl_pkg::out_count_t out_entry_count;
  mtfl_pkg::out_pos_t out_found_position;

  mtfl_pkg::entry_t list_copy [mtfl_pkg::CAPACITY];
  int list_len;
  list_result_t pending_results [$];
  int error_count;
  int send_idle_pct;
  int stall_pct;
  int stuck_cycles;

  move_to_front_keyed_list dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_entry_key       (in_entry_key),
    .in_entry_value     (in_entry_value),
    .in_entry_level     (in_entry_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_entry_count    (out_entry_count),
    .out_found_position (out_found_position)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // First match scanning from the front, or -1 when the key is absent.
  function automatic int find_position(key_t key);
    int i;
    int found;
    found = -1;
    for (i = 0; i < list_len; i++) begin
      if (found < 0 && list_copy[i].key == key) found = i;
    end
    return found;
  endfunction

  function automatic list_result_t apply_request(logic op, key_t key, value_t value,
                                                 level_t level);
    list_result_t res;
    int found;
    int i;
    found = find_position(key);
    res.position = '0;
    if (op == mtfl_pkg::OP_INSERT) begin
      if (found >= 0) begin
        res.status = mtfl_pkg::STAT_PRESENT;
        res.position = mtfl_pkg::out_pos_t'(found);
      end else if (list_len >= mtfl_pkg::CAPACITY) begin
        res.status = mtfl_pkg::STAT_FULL;
      end else begin
        for (i = list_len; i > 0; i--) list_copy[i] = list_copy[i-1];
        list_copy[0].key = key;
        list_copy[0].value = value;
        list_copy[0].level = level;
        list_len++;
        res.status = mtfl_pkg::STAT_INSERTED;
      end
    end else begin
      if (found >= 0) begin
        for (i = found; i > 0; i--) list_copy[i] = list_copy[i-1];
        list_copy[0].key = key;
        list_copy[0].value = value;
        list_copy[0].level = level;
        res.status = mtfl_pkg::STAT_MOVED;
        res.position = mtfl_pkg::out_pos_t'(found);
      end else begin
        res.status = mtfl_pkg::STAT_NOT_FOUND;
      end
    end
    res.count = mtfl_pkg::out_count_t'(list_len);
    return res;
  endfunction

  function automatic key_t absent_key();
    key_t key;
    key = key_t'($urandom);
    while (find_position(key) >= 0) key = key_t'($urandom);
    return key;
  endfunction

  // Mostly keys that are listed, some that differ from a listed key in one bit, some random.
  function automatic key_t pick_key();
    key_t key;
    int roll;
    roll = $urandom_range(99);
    if (list_len == 0 || roll >= 80) begin
      key = key_t'($urandom);
    end else begin
      key = list_copy[$urandom_range(list_len - 1)].key;
      if (roll >= 60) key ^= key_t'(1) << $urandom_range(mtfl_pkg::KEY_W - 1);
    end
    return key;
  endfunction

  function automatic logic pick_opcode();
    return $urandom_range(1) ? mtfl_pkg::OP_MOVE : mtfl_pkg::OP_INSERT;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(logic op, key_t key, value_t value, level_t level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_entry_key <= key;
    in_entry_value <= value;
    in_entry_level <= level;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(apply_request(op, key, value, level));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_basic_ops();
    send_idle_pct = 0;
    stall_pct = 0;
    send_request(mtfl_pkg::OP_MOVE, 16'h1234, 32'sd5, 4'd3);
    send_request(mtfl_pkg::OP_INSERT, 16'h0000, 32'h8000_0000, 4'd0);
    send_request(mtfl_pkg::OP_INSERT, 16'hFFFF, 32'h7FFF_FFFF, 4'hF);
    send_request(mtfl_pkg::OP_INSERT, 16'h0000, -32'sd1, 4'd9);
    send_request(mtfl_pkg::OP_MOVE, 16'hFFFF, 32'sd0, 4'd5);
    send_request(mtfl_pkg::OP_INSERT, 16'h8000, -32'sd1, 4'd8);
    send_request(mtfl_pkg::OP_INSERT, 16'h7FFF, 32'sd1, 4'd7);
    send_request(mtfl_pkg::OP_MOVE, 16'h0000, 32'h7FFF_FFFF, 4'hF);
    send_request(mtfl_pkg::OP_MOVE, 16'h0001, 32'sd2, 4'd1);
    send_request(mtfl_pkg::OP_INSERT, 16'h5555, 32'h5555_5555, 4'h5);
    send_request(mtfl_pkg::OP_INSERT, 16'hAAAA, 32'hAAAA_AAAA, 4'hA);
    send_request(mtfl_pkg::OP_MOVE, 16'h7FFF, 32'h8000_0000, 4'd0);
    send_request(mtfl_pkg::OP_INSERT, 16'hFFFF, 32'sd3, 4'd2);
    send_request(mtfl_pkg::OP_MOVE, 16'hFFFE, 32'sd4, 4'd4);
    wait_for_results();
  endtask

  task automatic test_traffic(int idle_pct, int hold_pct, int count);
    int i;
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    for (i = 0; i < count; i++) begin
      send_request(pick_opcode(), pick_key(), value_t'($urandom), level_t'($urandom_range(15)));
    end
    wait_for_results();
  endtask

  // Fills the list, then hits the full case, the last position and an absent key, then random traffic.
  task automatic test_full_list();
    int i;
    send_idle_pct = 0;
    stall_pct = 0;
    while (list_len < mtfl_pkg::CAPACITY) begin
      send_request(mtfl_pkg::OP_INSERT, absent_key(), value_t'($urandom),
                   level_t'($urandom_range(15)));
    end
    send_request(mtfl_pkg::OP_INSERT, absent_key(), value_t'($urandom),
                 level_t'($urandom_range(15)));
    send_request(mtfl_pkg::OP_INSERT, list_copy[mtfl_pkg::CAPACITY-1].key, 32'sd7, 4'd7);
    send_request(mtfl_pkg::OP_MOVE, list_copy[mtfl_pkg::CAPACITY-1].key, 32'sd9, 4'd9);
    send_request(mtfl_pkg::OP_MOVE, absent_key(), 32'sd1, 4'd1);
    send_idle_pct = 18;
    stall_pct = 18;
    for (i = 0; i < 40; i++) begin
      send_request(pick_opcode(), pick_key(), value_t'($urandom), level_t'($urandom_range(15)));
    end
    wait_for_results();
  endtask

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, expected %s", out_status, want.status.name()));
        if (out_entry_count !== want.count)
          report_mismatch($sformatf("entry count %0d, expected %0d", out_entry_count, want.count));
        if (out_found_position !== want.position)
          report_mismatch($sformatf("found position %0d, expected %0d",
                                    out_found_position, want.position));
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("move_to_front_keyed_list_tb failed");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= mtfl_pkg::OP_INSERT;
    in_entry_key <= '0;
    in_entry_value <= '0;
    in_entry_level <= '0;
    out_stall <= 1'b0;
    error_count = 0;
    list_len = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_basic_ops();
    test_traffic(0, 0, 150);
    test_traffic(88, 0, 150);
    test_traffic(0, 88, 150);
    test_traffic(18, 18, 150);
    test_full_list();
    stall_pct = 0;
    repeat (SETTLE_TICKS) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("move_to_front_keyed_list_tb passed");
    end else begin
      $display("move_to_front_keyed_list_tb failed");
    end
    $finish;
  end

endmodule
